[design/fts_pkg.sv]
// ----------------------------------------------------------------------------
// fts_pkg
// Shared constants of the frame timing sanitizer: item kinds and the
// positions of the correction flags in a result item.
// ----------------------------------------------------------------------------
package fts_pkg;

	localparam int FLAG_BITS = 6;

	// kind field of an update item
	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	// bit positions in fix_flags
	localparam int FL_FUTURE   = 0;
	localparam int FL_DL_EARLY = 1;
	localparam int FL_PT_EARLY = 2;
	localparam int FL_LAG      = 3;
	localparam int FL_FT_BACK  = 4;
	localparam int FL_PT_BACK  = 5;

	typedef logic [FLAG_BITS-1:0] flags_t;

endpackage

[design/fts_req_if.sv]
// ----------------------------------------------------------------------------
// fts_req_if
// Update channel of the frame timing sanitizer: valid/ready plus one
// frame update or clear item.
// ----------------------------------------------------------------------------
interface fts_req_if #(
	parameter int TIME_BITS     = 63,
	parameter int INTERVAL_BITS = 32
);
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [TIME_BITS-1:0]     in_frame_time;
	logic [TIME_BITS-1:0]     in_deadline;
	logic [TIME_BITS-1:0]     in_presentation_time;
	logic [INTERVAL_BITS-1:0] in_interval;
	logic [TIME_BITS-1:0]     now_time;

	modport source (
		output valid, kind, in_frame_time, in_deadline, in_presentation_time,
		       in_interval, now_time,
		input  ready
	);
	modport sink (
		input  valid, kind, in_frame_time, in_deadline, in_presentation_time,
		       in_interval, now_time,
		output ready
	);
endinterface

[design/fts_rsp_if.sv]
// ----------------------------------------------------------------------------
// fts_rsp_if
// Result channel of the frame timing sanitizer: valid/ready plus one
// sanitized timing item.
// ----------------------------------------------------------------------------
interface fts_rsp_if #(
	parameter int TIME_BITS     = 63,
	parameter int INTERVAL_BITS = 32,
	parameter int COUNT_BITS    = 32
);
	logic                      valid;
	logic                      ready;
	logic [TIME_BITS-1:0]      out_frame_time;
	logic [TIME_BITS-1:0]      out_deadline;
	logic [TIME_BITS-1:0]      out_presentation_time;
	logic [INTERVAL_BITS-1:0]  out_interval;
	logic [TIME_BITS-1:0]      time_delta;
	logic [fts_pkg::FLAG_BITS-1:0] fix_flags;
	logic [COUNT_BITS-1:0]     frames_seen;

	modport source (
		output valid, out_frame_time, out_deadline, out_presentation_time,
		       out_interval, time_delta, fix_flags, frames_seen,
		input  ready
	);
	modport sink (
		input  valid, out_frame_time, out_deadline, out_presentation_time,
		       out_interval, time_delta, fix_flags, frames_seen,
		output ready
	);
endinterface

[design/frame_timing_sanitizer.sv]
// ----------------------------------------------------------------------------
// frame_timing_sanitizer
// Cleans up frame timing: clamps, lag skip, monotonic frame/present times.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per display frame: kind selects a frame update or
//   a clear of all tracked state. rsp returns exactly one item per req item.
//   An item is accepted when valid and ready are both high on a clock edge.
//   One item is processed at a time; req.ready is high only while idle.
// Processing steps:
//   clear item:              accept, then the output step
//   update, no lag skip:     clamps, lag, check, monotonic fixes, output
//   update with lag skip:    also divider and adjust steps
//   The lag skip is set by the remainder (lag mod interval), computed by a
//   restoring divider that takes one bit of the lag per cycle.
//   Each other step does a wide compare, subtract or saturating add.
// Stalls: the result sits in an output register; a new item is taken while
//   it waits, and processing holds in its last step until rsp frees it.
// Reset: arst_n clears the frame history, counter and delta, and drops
//   rsp.valid; an item can be taken at the first clock edge after release.
// ----------------------------------------------------------------------------
module frame_timing_sanitizer #(
	parameter int TIME_BITS     = 63,
	parameter int INTERVAL_BITS = 32,
	parameter int COUNT_BITS    = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	fts_req_if.sink   req,
	fts_rsp_if.source rsp
);
	import fts_pkg::*;

	localparam int CMP_BITS = (TIME_BITS > INTERVAL_BITS) ? TIME_BITS : INTERVAL_BITS;
	localparam int DIV_CNT_BITS = $clog2(TIME_BITS);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CLAMP1 = 4'd1;
	localparam logic [3:0] S_CLAMP2 = 4'd2;
	localparam logic [3:0] S_CLAMP3 = 4'd3;
	localparam logic [3:0] S_LAG    = 4'd4;
	localparam logic [3:0] S_CHK    = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_ADJ1   = 4'd7;
	localparam logic [3:0] S_ADJ2   = 4'd8;
	localparam logic [3:0] S_ADJ3   = 4'd9;
	localparam logic [3:0] S_MONO1  = 4'd10;
	localparam logic [3:0] S_MONO2  = 4'd11;
	localparam logic [3:0] S_EMIT   = 4'd12;

	logic [3:0]               state_q;
	logic                     kind_q;
	logic [TIME_BITS-1:0]     ft_q, dl_q, pt_q, now_q, lag_q;
	logic [INTERVAL_BITS-1:0] iv_q, rem_q;
	flags_t                   flags_q;
	logic [DIV_CNT_BITS-1:0]  div_cnt_q;

	logic [TIME_BITS-1:0]     prev_ft_q, prev_pt_q, delta_q, dnext_q;
	logic [COUNT_BITS-1:0]    cnt_q;

	logic                     out_vld_q;
	logic [TIME_BITS-1:0]     res_ft_q, res_dl_q, res_pt_q;
	logic [INTERVAL_BITS-1:0] res_iv_q;
	flags_t                   res_flags_q;

	logic                     in_acc;
	logic                     out_free;
	logic [INTERVAL_BITS:0]   trial;
	logic [INTERVAL_BITS:0]   trial_diff;
	logic [TIME_BITS-1:0]     off;
	logic [TIME_BITS:0]       dl_sum, pt_sum, ft_diff, pt_diff;
	logic                     first;

	assign in_acc   = req.valid && req.ready;
	assign out_free = !out_vld_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);

	assign trial      = {rem_q, lag_q[TIME_BITS-1]};
	assign trial_diff = trial - {1'b0, iv_q};
	// remainder is below the interval, which is at most the lag
	assign off     = TIME_BITS'(CMP_BITS'(rem_q));
	assign dl_sum  = {1'b0, dl_q} + {1'b0, lag_q};
	assign pt_sum  = {1'b0, pt_q} + {1'b0, lag_q};
	assign ft_diff = {1'b0, ft_q} - {1'b0, prev_ft_q};
	assign pt_diff = {1'b0, pt_q} - {1'b0, prev_pt_q};
	assign first   = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
			prev_ft_q <= '0;
			prev_pt_q <= '0;
			delta_q   <= '0;
			cnt_q     <= '0;
		end else begin
			if (state_q == S_EMIT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						kind_q  <= req.kind;
						ft_q    <= req.in_frame_time;
						dl_q    <= req.in_deadline;
						pt_q    <= req.in_presentation_time;
						iv_q    <= req.in_interval;
						now_q   <= req.now_time;
						flags_q <= '0;
						state_q <= (req.kind == KIND_CLEAR) ? S_EMIT : S_CLAMP1;
					end
				end
				S_CLAMP1: begin
					if (ft_q > now_q) begin
						ft_q <= now_q;
						flags_q[FL_FUTURE] <= 1'b1;
					end
					state_q <= S_CLAMP2;
				end
				S_CLAMP2: begin
					if (dl_q < ft_q) begin
						dl_q <= ft_q;
						flags_q[FL_DL_EARLY] <= 1'b1;
					end
					state_q <= S_CLAMP3;
				end
				S_CLAMP3: begin
					if (pt_q < dl_q) begin
						pt_q <= dl_q;
						flags_q[FL_PT_EARLY] <= 1'b1;
					end
					state_q <= S_LAG;
				end
				S_LAG: begin
					lag_q   <= now_q - ft_q;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (iv_q != '0 && CMP_BITS'(lag_q) >= CMP_BITS'(iv_q)) begin
						rem_q     <= '0;
						div_cnt_q <= DIV_CNT_BITS'(TIME_BITS - 1);
						flags_q[FL_LAG] <= 1'b1;
						state_q   <= S_DIV;
					end else begin
						state_q <= S_MONO1;
					end
				end
				S_DIV: begin
					// one quotient bit per cycle; rotate the lag so it is intact at the end
					rem_q <= trial_diff[INTERVAL_BITS] ? trial[INTERVAL_BITS-1:0]
					                                   : trial_diff[INTERVAL_BITS-1:0];
					lag_q <= {lag_q[TIME_BITS-2:0], lag_q[TIME_BITS-1]};
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						state_q <= S_ADJ1;
					end
				end
				S_ADJ1: begin
					lag_q   <= lag_q - off;
					state_q <= S_ADJ2;
				end
				S_ADJ2: begin
					ft_q    <= now_q - off;
					dl_q    <= dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];
					state_q <= S_ADJ3;
				end
				S_ADJ3: begin
					pt_q    <= pt_sum[TIME_BITS] ? '1 : pt_sum[TIME_BITS-1:0];
					state_q <= S_MONO1;
				end
				S_MONO1: begin
					// stage the new delta; the waiting result still shows the old one
					if (!first) begin
						if (ft_diff[TIME_BITS]) begin
							ft_q    <= prev_ft_q;
							dnext_q <= '0;
							flags_q[FL_FT_BACK] <= 1'b1;
						end else begin
							dnext_q <= ft_diff[TIME_BITS-1:0];
						end
					end else begin
						dnext_q <= delta_q;
					end
					state_q <= S_MONO2;
				end
				S_MONO2: begin
					if (!first && pt_diff[TIME_BITS]) begin
						pt_q <= prev_pt_q;
						flags_q[FL_PT_BACK] <= 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// hold here until the output register is free
					if (out_free) begin
						state_q   <= S_IDLE;
						if (kind_q == KIND_CLEAR) begin
							prev_ft_q <= '0;
							prev_pt_q <= '0;
							delta_q   <= '0;
							cnt_q     <= '0;
						end else begin
							prev_ft_q <= ft_q;
							prev_pt_q <= pt_q;
							delta_q   <= dnext_q;
							if (cnt_q != '1) begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			if (kind_q == KIND_CLEAR) begin
				res_ft_q    <= '0;
				res_dl_q    <= '0;
				res_pt_q    <= '0;
				res_iv_q    <= '0;
				res_flags_q <= '0;
			end else begin
				res_ft_q    <= ft_q;
				res_dl_q    <= dl_q;
				res_pt_q    <= pt_q;
				res_iv_q    <= iv_q;
				res_flags_q <= flags_q;
			end
		end
	end

	assign rsp.valid                 = out_vld_q;
	assign rsp.out_frame_time        = res_ft_q;
	assign rsp.out_deadline          = res_dl_q;
	assign rsp.out_presentation_time = res_pt_q;
	assign rsp.out_interval          = res_iv_q;
	assign rsp.time_delta            = delta_q;
	assign rsp.fix_flags             = res_flags_q;
	assign rsp.frames_seen           = cnt_q;

	// presentation never ends up before the deadline
	a_pt_after_dl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.out_presentation_time >= rsp.out_deadline)
		else $error("presentation time before deadline");

	// partial remainder stays below the divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> CMP_BITS'(rem_q) < CMP_BITS'(iv_q))
		else $error("divider remainder out of range");

	// a lag skip needs a nonzero interval
	a_lag_iv: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.fix_flags[FL_LAG]) |-> rsp.out_interval != '0)
		else $error("lag skip with zero interval");

	// a result after a clear carries no corrections
	a_clear_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.frames_seen == '0) |-> rsp.fix_flags == '0)
		else $error("flags set on cleared result");

	// the frame history changes only when a result is issued
	a_hist_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_EMIT) |=> $stable(prev_ft_q) && $stable(cnt_q))
		else $error("frame history changed outside result issue");

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_timing_sanitizer. Directed items hit the
// clamps, lag skip, saturation, history and clear handling, then random
// frame sequences with noise mixed in run under four idling phases. Each
// result item is checked field by field against an in-bench prediction.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fts_pkg::*;

	localparam int TB_TIME_BITS     = 63;
	localparam int TB_INTERVAL_BITS = 32;
	localparam int TB_COUNT_BITS    = 32;
	localparam int CYCLE_LIMIT      = 1_000_000;

	typedef logic [TB_TIME_BITS-1:0]     tstamp_t;
	typedef logic [TB_INTERVAL_BITS-1:0] interval_t;
	typedef logic [TB_COUNT_BITS-1:0]    count_t;

	typedef struct {
		logic      kind;
		tstamp_t   frame;
		tstamp_t   deadline;
		tstamp_t   present;
		interval_t interval;
		tstamp_t   now;
	} update_t;

	typedef struct {
		tstamp_t   frame;
		tstamp_t   deadline;
		tstamp_t   present;
		interval_t interval;
		tstamp_t   delta;
		flags_t    flags;
		count_t    seen;
	} timing_t;

	logic clk = 1'b0;
	logic arst_n;

	fts_req_if #(.TIME_BITS(TB_TIME_BITS), .INTERVAL_BITS(TB_INTERVAL_BITS)) req ();
	fts_rsp_if #(.TIME_BITS(TB_TIME_BITS), .INTERVAL_BITS(TB_INTERVAL_BITS),
		.COUNT_BITS(TB_COUNT_BITS)) rsp ();

	frame_timing_sanitizer #(
		.TIME_BITS(TB_TIME_BITS),
		.INTERVAL_BITS(TB_INTERVAL_BITS),
		.COUNT_BITS(TB_COUNT_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// tracked history of the predictor
	tstamp_t last_frame;
	tstamp_t last_present;
	count_t  frame_count;
	tstamp_t held_delta;

	timing_t expected_q[$];
	int      err_count;
	int      results_checked;
	int      items_sent;
	int      clears_sent;
	flags_t  flags_covered;
	int      src_idle_pct;
	int      snk_stall_pct;
	int      cycle_count;
	tstamp_t timeline;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles, %0d results pending", cycle_count,
				expected_q.size());
			$display("tb: done, errors");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	function automatic tstamp_t sat_time(input tstamp_t a, input tstamp_t b);
		logic [TB_TIME_BITS:0] sum;
		sum = a + b;
		return sum[TB_TIME_BITS] ? '1 : sum[TB_TIME_BITS-1:0];
	endfunction

	// advance the tracked history by one item and return its result
	function automatic timing_t sanitize_update(input update_t u);
		timing_t   r;
		tstamp_t   ft;
		tstamp_t   dl;
		tstamp_t   pt;
		tstamp_t   lag;
		tstamp_t   rem;
		flags_t    fl;
		logic      first;
		r = '{default: '0};
		if (u.kind == KIND_CLEAR) begin
			last_frame = '0;
			last_present = '0;
			frame_count = '0;
			held_delta = '0;
			return r;
		end
		fl = '0;
		ft = u.frame;
		dl = u.deadline;
		pt = u.present;
		if (ft > u.now) begin
			ft = u.now;
			fl[FL_FUTURE] = 1'b1;
		end
		if (dl < ft) begin
			dl = ft;
			fl[FL_DL_EARLY] = 1'b1;
		end
		if (pt < dl) begin
			pt = dl;
			fl[FL_PT_EARLY] = 1'b1;
		end
		lag = u.now - ft;
		if (u.interval != '0 && lag >= tstamp_t'(u.interval)) begin
			rem = lag % tstamp_t'(u.interval);
			ft = u.now - rem;
			dl = sat_time(dl, lag - rem);
			pt = sat_time(pt, lag - rem);
			fl[FL_LAG] = 1'b1;
		end
		first = (frame_count == '0);
		if (frame_count != '1)
			frame_count++;
		if (!first) begin
			if (ft < last_frame) begin
				ft = last_frame;
				fl[FL_FT_BACK] = 1'b1;
			end
			if (pt < last_present) begin
				pt = last_present;
				fl[FL_PT_BACK] = 1'b1;
			end
			held_delta = ft - last_frame;
		end
		last_frame = ft;
		last_present = pt;
		r.frame = ft;
		r.deadline = dl;
		r.present = pt;
		r.interval = u.interval;
		r.delta = held_delta;
		r.flags = fl;
		r.seen = frame_count;
		return r;
	endfunction

	function automatic update_t mk(input logic kind, input tstamp_t ft, input tstamp_t dl,
			input tstamp_t pt, input interval_t iv, input tstamp_t now);
		update_t u;
		u.kind = kind;
		u.frame = ft;
		u.deadline = dl;
		u.present = pt;
		u.interval = iv;
		u.now = now;
		return u;
	endfunction

	function automatic tstamp_t rand_time();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return tstamp_t'({$urandom, $urandom});
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("tb: mismatch in %s at result %0d: got %h, want %h", what, results_checked,
			got, want);
		err_count++;
	endtask

	// enter and leave at a falling edge; valid stays high across back-to-back items
	task automatic send_item(input update_t u);
		timing_t want;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= u.kind;
		req.in_frame_time <= u.frame;
		req.in_deadline <= u.deadline;
		req.in_presentation_time <= u.present;
		req.in_interval <= u.interval;
		req.now_time <= u.now;
		do
			@(posedge clk);
		while (!req.ready);
		want = sanitize_update(u);
		expected_q.push_back(want);
		flags_covered |= want.flags;
		items_sent++;
		if (u.kind == KIND_CLEAR)
			clears_sent++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		timing_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected item", '0, '0);
			end else begin
				want = expected_q.pop_front();
				if (rsp.out_frame_time !== want.frame)
					report_mismatch("out_frame_time", rsp.out_frame_time, want.frame);
				if (rsp.out_deadline !== want.deadline)
					report_mismatch("out_deadline", rsp.out_deadline, want.deadline);
				if (rsp.out_presentation_time !== want.present)
					report_mismatch("out_presentation_time", rsp.out_presentation_time,
						want.present);
				if (rsp.out_interval !== want.interval)
					report_mismatch("out_interval", rsp.out_interval, want.interval);
				if (rsp.time_delta !== want.delta)
					report_mismatch("time_delta", rsp.time_delta, want.delta);
				if (rsp.fix_flags !== want.flags)
					report_mismatch("fix_flags", rsp.fix_flags, want.flags);
				if (rsp.frames_seen !== want.seen)
					report_mismatch("frames_seen", rsp.frames_seen, want.seen);
			end
			results_checked++;
		end
	end

	task automatic test_clear_and_extremes();
		send_item(mk(KIND_CLEAR, '1, '1, '1, '1, '1));
		send_item(mk(KIND_UPDATE, '0, '0, '0, '0, '0));
		send_item(mk(KIND_UPDATE, '1, '1, '1, '1, '1));
		// everything lands below the last frame
		send_item(mk(KIND_UPDATE, 1000, 0, 0, 0, 500));
		send_item(mk(KIND_CLEAR, '0, '0, '0, '0, '0));
	endtask

	task automatic test_clamps();
		send_item(mk(KIND_UPDATE, 1000, 900, 800, 0, 1000));
		send_item(mk(KIND_UPDATE, 5000, 4000, 3000, 0, 2000));
		send_item(mk(KIND_UPDATE, 2500, 2600, 2550, 0, 3000));
		send_item(mk(KIND_CLEAR, '0, '0, '0, '0, '0));
	endtask

	task automatic test_lag_skip();
		send_item(mk(KIND_UPDATE, 1000, 1500, 1600, 1000, 2000));
		send_item(mk(KIND_UPDATE, 1900, 1950, 2100, 1000, 2000));
		send_item(mk(KIND_UPDATE, 0, 5, 7, 1000, 10_007));
		send_item(mk(KIND_UPDATE, 12_000, 11_000, 11_500, 1, 20_000));
		// shift pushes deadline and presentation past the maximum
		send_item(mk(KIND_CLEAR, '0, '0, '0, '0, '0));
		send_item(mk(KIND_UPDATE, 0, '1 - 5, '1, 1, '1));
		send_item(mk(KIND_CLEAR, '0, '0, '0, '0, '0));
		send_item(mk(KIND_UPDATE, 0, 0, 0, '1, '1));
	endtask

	task automatic test_history();
		send_item(mk(KIND_CLEAR, 77, 88, 99, 3, 111));
		send_item(mk(KIND_UPDATE, 5000, 5500, 6000, 0, 5000));
		send_item(mk(KIND_UPDATE, 4000, 4200, 4500, 0, 4500));
		send_item(mk(KIND_UPDATE, 7000, 7100, 7200, 0, 7000));
		// first frame after a clear takes no history
		send_item(mk(KIND_CLEAR, '0, '0, '0, '0, '0));
		send_item(mk(KIND_UPDATE, 10, 20, 30, 0, 10));
	endtask

	task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
		update_t     u;
		logic [63:0] iv;
		logic [63:0] step;
		logic [63:0] lagv;
		tstamp_t     ft;
		tstamp_t     dl;
		tstamp_t     pt;
		int unsigned roll;
		src_idle_pct = idle_pct;
		snk_stall_pct = stall_pct;
		if ($urandom_range(0, 3) == 0)
			timeline = '1 - tstamp_t'($urandom_range(0, 1 << 24));
		else
			timeline = tstamp_t'({$urandom_range(0, 255), $urandom});
		for (int i = 0; i < n_items; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				u = mk(KIND_CLEAR, rand_time(), rand_time(), rand_time(), $urandom, rand_time());
			end else if (roll < 16) begin
				u = mk(KIND_UPDATE, rand_time(), rand_time(), rand_time(),
					($urandom_range(0, 5) == 0) ? interval_t'(0) : interval_t'($urandom),
					rand_time());
			end else begin
				case ($urandom_range(0, 9))
					0: iv = 0;
					1: iv = {32'd0, $urandom};
					default: iv = $urandom_range(1, 100_000);
				endcase
				step = (iv == 0) ? 64'($urandom_range(1, 20_000))
					: iv * $urandom_range(0, 3) + $urandom_range(0, 200);
				// jump back now and then so the history holds
				if ($urandom_range(0, 19) == 0)
					timeline = timeline - tstamp_t'($urandom_range(0, 50_000));
				else
					timeline = timeline + tstamp_t'(step);
				lagv = (iv == 0) ? 64'($urandom_range(0, 5000))
					: iv * $urandom_range(0, 4) + $urandom_range(0, 64'(iv) & 32'hFFFF);
				if ($urandom_range(0, 9) == 0)
					ft = timeline + tstamp_t'($urandom_range(1, 1000));
				else
					ft = timeline - tstamp_t'(lagv);
				if ($urandom_range(0, 7) == 0)
					dl = ft - tstamp_t'($urandom_range(1, 1000));
				else
					dl = ft + tstamp_t'($urandom_range(0, 2 * 100_000));
				if ($urandom_range(0, 7) == 0)
					pt = dl - tstamp_t'($urandom_range(1, 1000));
				else
					pt = dl + tstamp_t'($urandom_range(0, 5000));
				u = mk(KIND_UPDATE, ft, dl, pt, interval_t'(iv), timeline);
			end
			send_item(u);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.kind = KIND_UPDATE;
		req.in_frame_time = '0;
		req.in_deadline = '0;
		req.in_presentation_time = '0;
		req.in_interval = '0;
		req.now_time = '0;
		rsp.ready = 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		err_count = 0;
		results_checked = 0;
		items_sent = 0;
		clears_sent = 0;
		flags_covered = '0;
		cycle_count = 0;
		void'(sanitize_update(mk(KIND_CLEAR, '0, '0, '0, '0, '0)));
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_clear_and_extremes();
		test_clamps();
		test_lag_skip();
		test_history();
		test_random(210, 0, 0);
		test_random(210, 70, 0);
		test_random(210, 0, 70);
		test_random(210, 31, 31);
		req.valid <= 1'b0;

		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (TB_TIME_BITS + 12) @(posedge clk);

		$display("tb: %0d items sent (%0d clears), %0d results checked in %0d cycles",
			items_sent, clears_sent, results_checked, cycle_count);
		$display("tb: correction flags exercised %06b, %0d mismatches", flags_covered,
			err_count);
		if (err_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
